// ===== hw/rtl/sns_pkg.sv =====
// ----------------------------------------------------------------------------
// Spiking neuron step package
// Shared types and constants: configuration bundle, model codes, register
// indexes and fixed field widths.
// ----------------------------------------------------------------------------
package sns_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int WEIGHT_W   = 16;
  localparam int CYCLE_W    = 32;
  localparam int THR_W      = 15;
  localparam int LEAK_W     = 16;
  localparam int AXON_W     = 5;
  localparam int REFR_W     = 8;
  localparam int COUNT_W    = 16;

  typedef enum logic [2:0] {
    MODEL_STD    = 3'd0,
    MODEL_LIF    = 3'd1,
    MODEL_ALWAYS = 3'd2,
    MODEL_BURST  = 3'd3,
    MODEL_COLOR  = 3'd4,
    MODEL_FLOAT  = 3'd5
  } model_e;

  localparam logic [CFG_IDX_W-1:0] REG_MODEL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEAK      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AXON      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REFR      = 3'd4;

  // Leak of exactly -1.0 in Q4.12 turns the neuron off while it holds no charge
  localparam logic signed [LEAK_W-1:0] LEAK_OFF = 16'shF000;
  localparam logic signed [17-1:0]     Q_ONE    = 17'sd4096;
  localparam logic [COUNT_W-1:0]       COUNT_MIN = 16'h8000;

  localparam logic [THR_W-1:0]  THR_RST  = 15'd4096;
  localparam logic [LEAK_W-1:0] LEAK_RST = 16'd410;

  typedef struct packed {
    logic [2:0]               model;
    logic [THR_W-1:0]         threshold;
    logic signed [LEAK_W-1:0] leak;
    logic [AXON_W-1:0]        axon;
    logic [REFR_W-1:0]        refr;
  } cfg_t;

endpackage

// ===== hw/rtl/sns_if.sv =====
// ----------------------------------------------------------------------------
// Spiking neuron step channels
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface sns_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] weight;
  logic [31:0] cycle;

  modport source (output valid, kind, weight, cycle, input ready);
  modport sink   (input valid, kind, weight, cycle, output ready);
endinterface

interface sns_out_if #(
  parameter int CHARGE_WIDTH = 16
);
  logic                    valid;
  logic                    ready;
  logic                    fired;
  logic                    active;
  logic [CHARGE_WIDTH-1:0] charge;
  logic [CHARGE_WIDTH-1:0] previous_charge;

  modport source (output valid, fired, active, charge, previous_charge, input ready);
  modport sink   (input valid, fired, active, charge, previous_charge, output ready);
endinterface

interface sns_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/sns_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Spiking neuron configuration registers
// Holds model, threshold, leak, axon delay and refractory delay; flags a
// write of the standard model so the counters get cleared.
// ----------------------------------------------------------------------------
module sns_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_i,
  input  logic [sns_pkg::CFG_IDX_W-1:0]  idx_i,
  input  logic [sns_pkg::CFG_DATA_W-1:0] data_i,
  output sns_pkg::cfg_t                 cfg_o,
  output logic                          clr_o
);
  import sns_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_i) begin
      case (idx_i)
        REG_MODEL:     cfg_d.model     = data_i[2:0];
        REG_THRESHOLD: cfg_d.threshold = data_i[THR_W-1:0];
        REG_LEAK:      cfg_d.leak      = $signed(data_i[LEAK_W-1:0]);
        REG_AXON:      cfg_d.axon      = data_i[AXON_W-1:0];
        REG_REFR:      cfg_d.refr      = data_i[REFR_W-1:0];
        default:       cfg_d           = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.model     <= MODEL_STD;
      cfg_q.threshold <= THR_RST;
      cfg_q.leak      <= LEAK_RST;
      cfg_q.axon      <= '0;
      cfg_q.refr      <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
  assign clr_o = wr_i && (idx_i == REG_MODEL) && (data_i[2:0] == MODEL_STD);

endmodule

// ===== hw/rtl/sns_eval.sv =====
// ----------------------------------------------------------------------------
// Spiking neuron evaluation
// Next state and result for one item: charge add with saturation, or one
// firing step of the configured model.
// ----------------------------------------------------------------------------
module sns_eval #(
  parameter int CHARGE_WIDTH = 16,
  parameter int DELAY_BITS   = 32
) (
  input  sns_pkg::cfg_t                         cfg_i,
  input  logic                                  kind_i,
  input  logic signed [sns_pkg::WEIGHT_W-1:0]   weight_i,
  input  logic [sns_pkg::CYCLE_W-1:0]           cycle_i,
  input  logic signed [CHARGE_WIDTH-1:0]        cn_i,
  input  logic signed [CHARGE_WIDTH-1:0]        cs_i,
  input  logic signed [sns_pkg::COUNT_W-1:0]    ic_i,
  input  logic signed [DELAY_BITS:0]            ds_i,
  input  logic [sns_pkg::CYCLE_W-1:0]           fa_i,
  output logic signed [CHARGE_WIDTH-1:0]        cn_o,
  output logic signed [CHARGE_WIDTH-1:0]        cs_o,
  output logic signed [sns_pkg::COUNT_W-1:0]    ic_o,
  output logic signed [DELAY_BITS:0]            ds_o,
  output logic [sns_pkg::CYCLE_W-1:0]           fa_o,
  output logic                                  fired_o,
  output logic                                  active_o
);
  import sns_pkg::*;

  localparam int CW = CHARGE_WIDTH;
  localparam int DW = DELAY_BITS + 1;
  localparam int SW = CHARGE_WIDTH + 17;

  localparam logic signed [SW-1:0] CMAX_S = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] CMIN_S = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  function automatic logic signed [CW-1:0] sat(input logic signed [SW-1:0] x);
    logic signed [CW-1:0] r;
    if (x > CMAX_S) begin
      r = CMAX_S[CW-1:0];
    end else if (x < CMIN_S) begin
      r = CMIN_S[CW-1:0];
    end else begin
      r = x[CW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SW-1:0] ext(input logic signed [CW-1:0] x);
    return {{(SW-CW){x[CW-1]}}, x};
  endfunction

  logic signed [SW-1:0]      thr_s;
  logic signed [SW-1:0]      w_s;
  logic signed [COUNT_W-1:0] leak_int;
  logic signed [COUNT_W-1:0] leak_int_min1;
  logic signed [16:0]        factor;
  logic signed [SW-1:0]      prod;
  logic signed [SW-1:0]      rnd;
  logic [CYCLE_W:0]          refr_end;
  logic                      refr_hit;
  logic                      axon_fits;

  logic signed [CW-1:0]      cn;
  logic signed [CW-1:0]      cs;
  logic signed [COUNT_W-1:0] ic;
  logic signed [DW-1:0]      ds;
  logic [CYCLE_W-1:0]        fa;
  logic                      fired;
  logic                      active;
  logic                      done;

  assign thr_s = $signed({{(SW-THR_W){1'b0}}, cfg_i.threshold});
  assign w_s   = {{(SW-WEIGHT_W){weight_i[WEIGHT_W-1]}}, weight_i};

  // Integer part of the leak, truncated toward zero
  assign leak_int = {{(COUNT_W-4){cfg_i.leak[15]}}, cfg_i.leak[15:12]}
                  + COUNT_W'(cfg_i.leak[15] && (cfg_i.leak[11:0] != '0));
  assign leak_int_min1 = (leak_int < 16'sd1) ? 16'sd1 : leak_int;

  assign factor   = Q_ONE - {cfg_i.leak[15], cfg_i.leak};
  assign refr_end = {1'b0, fa_i} + {{(CYCLE_W+1-REFR_W){1'b0}}, cfg_i.refr};
  assign refr_hit = {1'b0, cycle_i} < refr_end;
  assign axon_fits = int'(cfg_i.axon) < DELAY_BITS;

  // Leak multiply sees the charge after the refractory zero and the clamp
  always_comb begin
    logic signed [CW-1:0] c;
    c = cn_i;
    if (refr_hit) begin
      c = '0;
    end
    if (cfg_i.model != MODEL_FLOAT && c[CW-1]) begin
      c = '0;
    end
    prod = ext(c) * {{(SW-17){factor[16]}}, factor};
    rnd  = (prod + SW'(2048)) >>> 12;
  end

  always_comb begin
    cn     = cn_i;
    cs     = cs_i;
    ic     = ic_i;
    ds     = ds_i;
    fa     = fa_i;
    fired  = 1'b0;
    active = 1'b0;
    done   = 1'b0;
    if (!kind_i) begin
      cn     = sat(ext(cn_i) + w_s);
      active = ext(cn) >= thr_s;
    end else begin
      if (cfg_i.leak == LEAK_OFF && cn == '0) begin
        cs   = cn;
        done = 1'b1;
      end
      if (!done && cfg_i.model == MODEL_COLOR) begin
        active = 1'b1;
        fired  = 1'b1;
        done   = 1'b1;
      end
      if (!done) begin
        if (cfg_i.model == MODEL_ALWAYS) begin
          if (!cfg_i.leak[15]) begin
            if (ic != COUNT_MIN) begin
              ic = ic - 16'sd1;
            end
            if (ic[COUNT_W-1] || ic == '0) begin
              cn = sat(ext(cn) + thr_s);
            end
          end
          active = 1'b1;
        end
        if (cfg_i.model == MODEL_BURST) begin
          if (cn[CW-1]) begin
            ds = '0;
          end
          if (!ds[DW-1] && ds != '0) begin
            if (ic != COUNT_MIN) begin
              ic = ic - 16'sd1;
            end
            if (ic[COUNT_W-1] || ic == '0) begin
              ds = ds - DW'(1);
              cn = sat(ext(cn) + thr_s);
              if (!ds[DW-1] && ds != '0) begin
                ic = leak_int;
              end
            end
            active = 1'b1;
          end else if (ds == '0) begin
            ds = '1;
          end
        end
        if (refr_hit) begin
          cn     = '0;
          active = 1'b1;
        end
        if (cfg_i.model != MODEL_FLOAT && cn[CW-1]) begin
          cn = '0;
        end
        if (cn != cs) begin
          cs     = cn;
          active = 1'b1;
        end
        // Advance the axon delay line; its low bit is a delayed spike
        if (cfg_i.model == MODEL_LIF && ds != '0) begin
          ds     = ds >>> 1;
          active = 1'b1;
          if (ds[0]) begin
            fired = 1'b1;
            done  = 1'b1;
          end
        end
      end
      if (!done) begin
        if (ext(cn) >= thr_s) begin
          if (cfg_i.model == MODEL_LIF && cfg_i.axon != '0) begin
            if (axon_fits) begin
              ds = ds | (DW'(1) << cfg_i.axon);
            end
            fa     = cycle_i;
            cn     = '0;
            active = 1'b1;
          end else begin
            if (cfg_i.model == MODEL_BURST && ds[DW-1]) begin
              ic = leak_int_min1;
              ds = DW'(cfg_i.axon) - DW'(1);
            end
            if (cfg_i.model == MODEL_ALWAYS) begin
              ic = {{(COUNT_W-AXON_W){1'b0}}, cfg_i.axon};
            end
            if (cfg_i.model != MODEL_FLOAT) begin
              cn = '0;
            end
            fa    = cycle_i;
            fired = 1'b1;
          end
        end else if (cfg_i.model == MODEL_LIF) begin
          cn     = sat(rnd);
          active = 1'b1;
        end
      end
    end
  end

  assign cn_o     = cn;
  assign cs_o     = cs;
  assign ic_o     = ic;
  assign ds_o     = ds;
  assign fa_o     = fa;
  assign fired_o  = fired;
  assign active_o = active;

endmodule

// ===== hw/rtl/spiking_neuron_step_top.sv =====
// ----------------------------------------------------------------------------
// Spiking neuron step
// One leaky integrate-and-fire neuron with always, burst, color and float
// value models, driven by add-charge and step items.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries items: kind 0 adds weight to the charge, kind 1 runs one
//   firing step at the given cycle number. out_o returns exactly one result
//   per item: fired, active, and charge and previous charge in Q4.12.
//   cfg_i writes a register by index (0 model, 1 threshold, 2 leak, 3 axon
//   delay, 4 refractory delay); it is always ready. Write only while no item
//   is in flight. Writing the standard model clears the burst and interval
//   counters.
//   An accepted item is held in the input register, and its result in the
//   result register until out_o takes it. Throughput is one item per cycle
//   while out_o does not stall: the input register feeds the evaluation
//   logic, which updates the neuron state and loads the result register.
//   When out_o stalls, the result register holds, the input register holds
//   one more item, and in_i.ready drops until the result is taken.
//   Reset clears the charge, counters and delay line and loads the register
//   defaults (threshold 1.0, leak 0.1).
// ----------------------------------------------------------------------------
module spiking_neuron_step_top #(
  parameter int CHARGE_WIDTH = 16,
  parameter int DELAY_BITS   = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sns_in_if.sink     in_i,
  sns_out_if.source  out_o,
  sns_cfg_if.sink    cfg_i
);
  import sns_pkg::*;

  localparam int CW = CHARGE_WIDTH;
  localparam int DW = DELAY_BITS + 1;

  cfg_t cfg;
  logic clr;

  // Input register
  logic                       s1_valid_q, s1_valid_d;
  logic                       s1_kind_q;
  logic signed [WEIGHT_W-1:0] s1_weight_q;
  logic [CYCLE_W-1:0]         s1_cycle_q;

  // Neuron state
  logic signed [CW-1:0]      cn_q, cn_d;
  logic signed [CW-1:0]      cs_q, cs_d;
  logic signed [COUNT_W-1:0] ic_q, ic_d;
  logic signed [DW-1:0]      ds_q, ds_d;
  logic [CYCLE_W-1:0]        fa_q, fa_d;

  // Result register
  logic                 out_valid_q, out_valid_d;
  logic                 fired_q, fired_d;
  logic                 active_q, active_d;
  logic signed [CW-1:0] charge_q;
  logic signed [CW-1:0] prev_q;

  logic in_acc;
  logic advance;

  assign cfg_i.ready = 1'b1;

  sns_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (cfg_i.valid),
    .idx_i  (cfg_i.index),
    .data_i (cfg_i.data),
    .cfg_o  (cfg),
    .clr_o  (clr)
  );

  sns_eval #(
    .CHARGE_WIDTH (CHARGE_WIDTH),
    .DELAY_BITS   (DELAY_BITS)
  ) u_eval (
    .cfg_i    (cfg),
    .kind_i   (s1_kind_q),
    .weight_i (s1_weight_q),
    .cycle_i  (s1_cycle_q),
    .cn_i     (cn_q),
    .cs_i     (cs_q),
    .ic_i     (ic_q),
    .ds_i     (ds_q),
    .fa_i     (fa_q),
    .cn_o     (cn_d),
    .cs_o     (cs_d),
    .ic_o     (ic_d),
    .ds_o     (ds_d),
    .fa_o     (fa_d),
    .fired_o  (fired_d),
    .active_o (active_d)
  );

  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_acc     = in_i.valid && in_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cn_q        <= '0;
      cs_q        <= '0;
      ic_q        <= '0;
      ds_q        <= '0;
      fa_q        <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (clr) begin
        ic_q <= '0;
        ds_q <= '0;
      end else if (advance) begin
        cn_q <= cn_d;
        cs_q <= cs_d;
        ic_q <= ic_d;
        ds_q <= ds_d;
        fa_q <= fa_d;
      end
    end
  end

  // Payload registers: load on accept / advance, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_kind_q   <= in_i.kind;
      s1_weight_q <= in_i.weight;
      s1_cycle_q  <= in_i.cycle;
    end
    if (advance) begin
      fired_q  <= fired_d;
      active_q <= active_d;
      charge_q <= cn_d;
      prev_q   <= cs_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.fired           = fired_q;
  assign out_o.active          = active_q;
  assign out_o.charge          = charge_q;
  assign out_o.previous_charge = prev_q;

endmodule
